// ===== hdl/lifo_stack_with_key_update_defines.svh =====
// assertion macros for the lifo stack with key update
// used by the top level; expects clk and rst_n in the including scope
`ifndef LIFO_STACK_WITH_KEY_UPDATE_DEFINES_SVH
`define LIFO_STACK_WITH_KEY_UPDATE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/lsk_pkg.sv =====
// shared types and constants for the lifo stack with key update
// no dependencies; used by lsk_cell and the top level
package lsk_pkg;

    // field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned ID_W     = 32;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned FILL_W   = 5;

    // packed stream widths, padded to whole bytes
    localparam int unsigned S_DATA_W = 80;
    localparam int unsigned M_DATA_W = 48;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_REPLACE = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOMATCH  = 2'd3
    } status_t;

    // control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SELECT = 2'b10
    } state_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic push;   // shift toward the bottom, new entry into the top cell
        logic pop;    // shift toward the top
        logic cmp;    // capture id compare result
        logic wr;     // overwrite the granted cell
    } cell_ctl_t;

endpackage

// ===== hdl/lifo_stack_with_key_update.sv =====
// top level of the lifo stack with key update: control, cell chain, output register
// depends on lsk_pkg, lsk_cell, lsk_prio and lifo_stack_with_key_update_defines.svh
//
//  channel | dir | handshake         | payload
//  s_axis  | in  | s_tvalid/s_tready | s_tdata: cmd, new_id, new_char, match_id
//  m_axis  | out | m_tvalid/m_tready | m_tdata: status, entry_id, entry_char, fill_level
//
// push, pop and clear: the result is registered at the accepting edge.
// replace: the cells capture the id compare at the accepting edge; the bottom-first
// priority pick and the overwrite happen in the select state that follows.
// a new request is taken in the cycle the previous result leaves or after it has left.
// reset clears the fill count, the sequencer and the output valid; cell contents
// are not cleared and are never read before a push writes them.
`include "lifo_stack_with_key_update_defines.svh"

module lifo_stack_with_key_update
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [1:0] cmd, [33:2] new_id, [41:34] new_char, [73:42] match_id, [79:74] zero
    input  logic [lsk_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [1:0] status, [33:2] entry_id, [41:34] entry_char, [46:42] fill_level, [47] zero
    output logic [lsk_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    // input fields
    lsk_pkg::cmd_t                in_cmd;
    logic [lsk_pkg::ID_W-1:0]     in_new_id;
    logic [lsk_pkg::CHAR_W-1:0]   in_new_char;
    logic [lsk_pkg::ID_W-1:0]     in_match_id;

    // control
    lsk_pkg::state_t              state_reg;
    lsk_pkg::state_t              state_next;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_free;
    logic                         acc;
    logic                         empty;
    logic                         full;
    lsk_pkg::cell_ctl_t           ctl;

    // payload registers
    lsk_pkg::status_t             status_reg;
    lsk_pkg::status_t             status_next;
    logic [lsk_pkg::ID_W-1:0]     eid_reg;
    logic [lsk_pkg::ID_W-1:0]     eid_next;
    logic [lsk_pkg::CHAR_W-1:0]   ech_reg;
    logic [lsk_pkg::CHAR_W-1:0]   ech_next;
    logic [lsk_pkg::ID_W-1:0]     wr_id_reg;
    logic [lsk_pkg::CHAR_W-1:0]   wr_char_reg;

    // cell chain wiring
    logic [lsk_pkg::ID_W-1:0]     cell_id   [DEPTH];
    logic [lsk_pkg::CHAR_W-1:0]   cell_chr  [DEPTH];
    logic [DEPTH-1:0]             cell_hit;
    logic [DEPTH-1:0]             cell_act;
    logic [DEPTH-1:0]             grant;
    logic                         any_hit;

    // unpack the request
    assign in_cmd      = lsk_pkg::cmd_t'(s_tdata[1:0]);
    assign in_new_id   = s_tdata[33:2];
    assign in_new_char = s_tdata[41:34];
    assign in_match_id = s_tdata[73:42];

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == lsk_pkg::ST_IDLE) && out_free;
    assign acc      = s_tvalid && s_tready;
    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));

    // cell control broadcast
    always_comb
    begin
        ctl.push = acc && (in_cmd == lsk_pkg::CMD_PUSH) && !full;
        ctl.pop  = acc && (in_cmd == lsk_pkg::CMD_POP) && !empty;
        ctl.cmp  = acc && (in_cmd == lsk_pkg::CMD_REPLACE);
        ctl.wr   = (state_reg == lsk_pkg::ST_SELECT);
    end

    // row of cells, cell 0 is the top of the stack
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [lsk_pkg::ID_W-1:0]   up_id;
        logic [lsk_pkg::CHAR_W-1:0] up_chr;
        logic [lsk_pkg::ID_W-1:0]   lo_id;
        logic [lsk_pkg::CHAR_W-1:0] lo_chr;

        if (i == 0)
        begin : g_top
            assign up_id  = in_new_id;
            assign up_chr = in_new_char;
        end
        else
        begin : g_mid_up
            assign up_id  = cell_id[i-1];
            assign up_chr = cell_chr[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_bottom
            assign lo_id  = '0;
            assign lo_chr = '0;
        end
        else
        begin : g_mid_lo
            assign lo_id  = cell_id[i+1];
            assign lo_chr = cell_chr[i+1];
        end

        assign cell_act[i] = (count_reg > CW'(i));

        lsk_cell u_cell
        (
            .clk        (clk),
            .ctl        (ctl),
            .upper_id   (up_id),
            .upper_char (up_chr),
            .lower_id   (lo_id),
            .lower_char (lo_chr),
            .match_id   (in_match_id),
            .active     (cell_act[i]),
            .grant      (grant[i]),
            .wr_id      (wr_id_reg),
            .wr_char    (wr_char_reg),
            .id         (cell_id[i]),
            .chr        (cell_chr[i]),
            .hit        (cell_hit[i])
        );
    end

    // bottom-first pick among matching cells
    lsk_prio #(.N(DEPTH)) u_prio
    (
        .hit   (cell_hit),
        .grant (grant),
        .any   (any_hit)
    );

    // sequencer, fill count and result
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        status_next    = status_reg;
        eid_next       = eid_reg;
        ech_next       = ech_reg;

        case (state_reg)
            lsk_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    out_valid_next = 1'b1;
                    status_next    = lsk_pkg::STAT_OK;
                    eid_next       = '0;
                    ech_next       = '0;
                    case (in_cmd)
                        lsk_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = lsk_pkg::STAT_OVERFLOW;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        lsk_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                status_next = lsk_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                eid_next   = cell_id[0];
                                ech_next   = cell_chr[0];
                            end
                        end
                        lsk_pkg::CMD_REPLACE:
                        begin
                            if (empty)
                            begin
                                status_next = lsk_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                // result comes from the select cycle
                                out_valid_next = 1'b0;
                                state_next     = lsk_pkg::ST_SELECT;
                            end
                        end
                        lsk_pkg::CMD_CLEAR:
                        begin
                            if (empty)
                            begin
                                status_next = lsk_pkg::STAT_EMPTY;
                            end
                            count_next = '0;
                        end
                        default:
                        begin
                            status_next = lsk_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            lsk_pkg::ST_SELECT:
            begin
                out_valid_next = 1'b1;
                state_next     = lsk_pkg::ST_IDLE;
                if (any_hit)
                begin
                    status_next = lsk_pkg::STAT_OK;
                    eid_next    = wr_id_reg;
                    ech_next    = wr_char_reg;
                end
                else
                begin
                    status_next = lsk_pkg::STAT_NOMATCH;
                    eid_next    = '0;
                    ech_next    = '0;
                end
            end
            default:
            begin
                state_next = lsk_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsk_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result and replace data registers
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        eid_reg    <= eid_next;
        ech_reg    <= ech_next;
        if (acc)
        begin
            wr_id_reg   <= in_new_id;
            wr_char_reg <= in_new_char;
        end
    end

    // pack the result; fill count is the live count after the last request
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, lsk_pkg::FILL_W'(count_reg), ech_reg, eid_reg, status_reg};

    // checks
    `LSK_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "fill count above depth")
    `LSK_ASSERT_NOW(a_grant_single, state_reg == lsk_pkg::ST_SELECT, $onehot0(grant), "replace grants more than one cell")
    `LSK_ASSERT_NEXT(a_overflow_hold, ctl.cmp == 1'b0 && acc && in_cmd == lsk_pkg::CMD_PUSH && full, m_tvalid && status_reg == lsk_pkg::STAT_OVERFLOW && $stable(count_reg), "overflow push changed the stack")
    `LSK_ASSERT_NEXT(a_replace_wait, acc && in_cmd == lsk_pkg::CMD_REPLACE && !empty, state_reg == lsk_pkg::ST_SELECT && !m_tvalid, "replace result shown before select")
    `LSK_ASSERT_NEXT(a_pop_count, ctl.pop, count_reg == $past(count_reg) - CW'(1), "pop did not lower the fill count")

endmodule

// ===== hdl/lsk_cell.sv =====
// one stack cell: holds an id and a character, shifts with its neighbors
// depends on lsk_pkg
module lsk_cell
(
    input  logic                           clk,
    input  lsk_pkg::cell_ctl_t             ctl,
    input  logic [lsk_pkg::ID_W-1:0]       upper_id,    // neighbor nearer the top
    input  logic [lsk_pkg::CHAR_W-1:0]     upper_char,
    input  logic [lsk_pkg::ID_W-1:0]       lower_id,    // neighbor nearer the bottom
    input  logic [lsk_pkg::CHAR_W-1:0]     lower_char,
    input  logic [lsk_pkg::ID_W-1:0]       match_id,
    input  logic                           active,      // cell holds a live entry
    input  logic                           grant,       // this cell wins the replace
    input  logic [lsk_pkg::ID_W-1:0]       wr_id,
    input  logic [lsk_pkg::CHAR_W-1:0]     wr_char,
    output logic [lsk_pkg::ID_W-1:0]       id,
    output logic [lsk_pkg::CHAR_W-1:0]     chr,
    output logic                           hit
);

    logic [lsk_pkg::ID_W-1:0]   id_reg;
    logic [lsk_pkg::ID_W-1:0]   id_next;
    logic [lsk_pkg::CHAR_W-1:0] chr_reg;
    logic [lsk_pkg::CHAR_W-1:0] chr_next;
    logic                       hit_reg;
    logic                       hit_next;

    // entry select: shift in, shift out, or overwrite
    always_comb
    begin
        id_next  = id_reg;
        chr_next = chr_reg;
        if (ctl.push)
        begin
            id_next  = upper_id;
            chr_next = upper_char;
        end
        else if (ctl.pop)
        begin
            id_next  = lower_id;
            chr_next = lower_char;
        end
        else if (ctl.wr && grant)
        begin
            id_next  = wr_id;
            chr_next = wr_char;
        end
    end

    // id compare, captured when a replace request comes in
    always_comb
    begin
        hit_next = hit_reg;
        if (ctl.cmp)
        begin
            hit_next = active && (id_reg == match_id);
        end
    end

    // payload storage, no reset
    always_ff @(posedge clk)
    begin
        id_reg  <= id_next;
        chr_reg <= chr_next;
        hit_reg <= hit_next;
    end

    assign id  = id_reg;
    assign chr = chr_reg;
    assign hit = hit_reg;

endmodule

// ===== hdl/lsk_prio.sv =====
// bottom-first priority pick over the cell hit vector
// no dependencies; highest index means nearest the bottom of the stack
module lsk_prio
#(
    parameter int unsigned N = 16
)
(
    input  logic [N-1:0] hit,
    output logic [N-1:0] grant,
    output logic         any
);

    logic [N-1:0] rev;
    logic [N-1:0] rev_grant;

    // reverse so the bottom cell becomes bit 0
    for (genvar i = 0; i < N; i++)
    begin : g_rev
        assign rev[i]   = hit[N-1-i];
        assign grant[i] = rev_grant[N-1-i];
    end

    // isolate lowest set bit of the reversed vector
    assign rev_grant = rev & (~rev + N'(1));
    assign any       = |hit;

endmodule

// ===== tb/sv/lifo_stack_with_key_update_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for lifo_stack_with_key_update: directed table, then random requests
// depends on lsk_pkg and the top level; results are checked against a shadow stack in this file
module lifo_stack_with_key_update_tb;
    import lsk_pkg::*;

    localparam int unsigned DEPTH         = 16;
    localparam int unsigned RANDOM_ITEMS  = 1300;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned DIRECTED_ROWS = 14;
    localparam int unsigned PAUSE_AT      = 650;

    typedef struct {
        status_t        status;
        logic [31:0]    entry_id;
        logic [7:0]     entry_char;
        logic [4:0]     fill_level;
    } stack_result_t;

    typedef struct {
        cmd_t           op;
        logic [31:0]    new_id;
        logic [7:0]     new_char;
        logic [31:0]    match_id;
        int unsigned    reps;
        bit             typed;
        stack_result_t  want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_DATA_W-1:0]    m_tdata;

    // shadow copy of the stack contents
    logic [31:0]    shadow_ids [DEPTH];
    logic [7:0]     shadow_chars [DEPTH];
    int unsigned    shadow_fill;

    stack_result_t  pending_results [$];
    stack_result_t  typed_result;
    bit             use_typed;
    bit             no_stall;
    int unsigned    error_count;
    int unsigned    cycle_count;
    int unsigned    rx_hold;
    logic [31:0]    id_pool [8];

    // directed requests; expected values typed in where they are plain
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_POP,     32'h0000_0000, 8'h00, 32'h0000_0000, 1,  1'b1,
          '{STAT_EMPTY, 32'h0, 8'h0, 5'd0}},
        '{CMD_REPLACE, 32'h0000_007b, 8'h5a, 32'h0000_0000, 1,  1'b1,
          '{STAT_EMPTY, 32'h0, 8'h0, 5'd0}},
        '{CMD_CLEAR,   32'h0000_0000, 8'h00, 32'h0000_0000, 1,  1'b1,
          '{STAT_EMPTY, 32'h0, 8'h0, 5'd0}},
        '{CMD_PUSH,    32'h8000_0000, 8'h00, 32'hffff_ffff, 1,  1'b1,
          '{STAT_OK, 32'h0, 8'h0, 5'd1}},
        '{CMD_PUSH,    32'h7fff_ffff, 8'hff, 32'h0000_0000, 1,  1'b1,
          '{STAT_OK, 32'h0, 8'h0, 5'd2}},
        '{CMD_PUSH,    32'h0000_0005, 8'h41, 32'h0000_0000, 12, 1'b0,
          '{STAT_OK, 32'h0, 8'h0, 5'd0}},
        '{CMD_PUSH,    32'hffff_ffff, 8'h80, 32'h0000_0000, 1,  1'b0,
          '{STAT_OK, 32'h0, 8'h0, 5'd0}},
        '{CMD_PUSH,    32'h0000_0000, 8'h01, 32'h0000_0000, 1,  1'b1,
          '{STAT_OK, 32'h0, 8'h0, 5'd16}},
        '{CMD_PUSH,    32'h0000_1234, 8'h33, 32'h0000_0000, 1,  1'b1,
          '{STAT_OVERFLOW, 32'h0, 8'h0, 5'd16}},
        '{CMD_REPLACE, 32'h0bad_cafe, 8'h7e, 32'h0000_0005, 1,  1'b0,
          '{STAT_OK, 32'h0, 8'h0, 5'd0}},
        '{CMD_REPLACE, 32'h1111_1111, 8'h22, 32'h5555_5555, 1,  1'b1,
          '{STAT_NOMATCH, 32'h0, 8'h0, 5'd16}},
        '{CMD_REPLACE, 32'h7fff_ffff, 8'hff, 32'h8000_0000, 1,  1'b1,
          '{STAT_OK, 32'h7fff_ffff, 8'hff, 5'd16}},
        '{CMD_POP,     32'h0000_0000, 8'h00, 32'h0000_0000, 1,  1'b0,
          '{STAT_OK, 32'h0, 8'h0, 5'd0}},
        '{CMD_CLEAR,   32'h0000_0000, 8'h00, 32'h0000_0000, 1,  1'b1,
          '{STAT_OK, 32'h0, 8'h0, 5'd0}}
    };

    lifo_stack_with_key_update #(
        .DEPTH      (DEPTH)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lifo_stack_with_key_update regression: fail");
        $finish;
    end

    // apply one request to the shadow stack and return the result it should give
    function automatic stack_result_t apply_stack_request(cmd_t op, logic [31:0] nid,
                                                          logic [7:0] nch, logic [31:0] mid);
        stack_result_t r;
        bit hit;
        int unsigned i;
        r = '{STAT_OK, 32'h0, 8'h0, 5'd0};
        hit = 1'b0;
        case (op)
            CMD_PUSH:
            begin
                if (shadow_fill < DEPTH)
                begin
                    shadow_ids[shadow_fill] = nid;
                    shadow_chars[shadow_fill] = nch;
                    shadow_fill++;
                end
                else
                    r.status = STAT_OVERFLOW;
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    shadow_fill--;
                    r.entry_id = shadow_ids[shadow_fill];
                    r.entry_char = shadow_chars[shadow_fill];
                end
            end
            CMD_REPLACE:
            begin
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // lowest matching entry wins
                    for (i = 0; i < shadow_fill; i++)
                    begin
                        if (!hit && shadow_ids[i] == mid)
                        begin
                            shadow_ids[i] = nid;
                            shadow_chars[i] = nch;
                            r.entry_id = nid;
                            r.entry_char = nch;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        r.status = STAT_NOMATCH;
                end
            end
            default:
            begin
                if (shadow_fill == 0)
                    r.status = STAT_EMPTY;
                shadow_fill = 0;
            end
        endcase
        r.fill_level = shadow_fill[4:0];
        return r;
    endfunction

    task automatic report_failure(string what, stack_result_t want, stack_result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected st=%0d id=%h ch=%h fill=%0d, got st=%0d id=%h ch=%h fill=%0d",
                     $time, what, want.status, want.entry_id, want.entry_char, want.fill_level,
                     got.status, got.entry_id, got.entry_char, got.fill_level);
    endtask

    // predict accepted requests, check accepted results
    always @(posedge clk)
    begin
        stack_result_t predicted;
        stack_result_t got;
        stack_result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                predicted = apply_stack_request(cmd_t'(s_tdata[1:0]), s_tdata[33:2],
                                                s_tdata[41:34], s_tdata[73:42]);
                pending_results.push_back(use_typed ? typed_result : predicted);
            end
            if (m_tvalid && m_tready)
            begin
                got.status = status_t'(m_tdata[1:0]);
                got.entry_id = m_tdata[33:2];
                got.entry_char = m_tdata[41:34];
                got.fill_level = m_tdata[46:42];
                if (pending_results.size() == 0)
                    report_failure("unexpected result", '{STAT_OK, 32'h0, 8'h0, 5'd0}, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.entry_id !== want.entry_id
                        || got.entry_char !== want.entry_char
                        || got.fill_level !== want.fill_level)
                        report_failure("result mismatch", want, got);
                end
            end
        end
    end

    // receiver side: random stall bursts
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if (!no_stall && $urandom_range(0, 5) == 0)
        begin
            rx_hold = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // drive one request at the falling edge and wait for it to be taken
    task automatic send_request(cmd_t op, logic [31:0] nid, logic [7:0] nch, logic [31:0] mid);
        s_tdata <= {6'd0, mid, nch, nid, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // optional sender gap before the next request
    task automatic sender_gap();
        int unsigned gap;
        gap = 0;
        if (!no_stall && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 4);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 9) < 6)
            return id_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    // push-heavy and pop-heavy phases so the stack swings between full and empty
    function automatic cmd_t pick_cmd(int unsigned n);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if ((n / 64) % 2 == 0)
        begin
            if (roll < 59)
                return CMD_PUSH;
            if (roll < 74)
                return CMD_POP;
        end
        else
        begin
            if (roll < 22)
                return CMD_PUSH;
            if (roll < 74)
                return CMD_POP;
        end
        if (roll < 99)
            return CMD_REPLACE;
        return CMD_CLEAR;
    endfunction

    // stimulus
    initial
    begin
        int unsigned row;
        int unsigned k;
        int unsigned n;
        cmd_t op;
        logic [31:0] mid;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        use_typed = 1'b0;
        typed_result = '{STAT_OK, 32'h0, 8'h0, 5'd0};
        no_stall = 1'b0;
        rx_hold = 0;
        error_count = 0;
        shadow_fill = 0;
        id_pool = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
                    $urandom, $urandom, $urandom, $urandom};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            for (k = 0; k < directed_rows[row].reps; k++)
            begin
                sender_gap();
                use_typed = directed_rows[row].typed;
                typed_result = directed_rows[row].want;
                send_request(directed_rows[row].op, directed_rows[row].new_id,
                             directed_rows[row].new_char, directed_rows[row].match_id);
            end
        end
        use_typed = 1'b0;

        // random requests
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_stall = (n >= 300 && n < 400) || (n >= RANDOM_ITEMS - 150);
            if (n == PAUSE_AT)
            begin
                // hold off until every outstanding result has been taken
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
            sender_gap();
            op = pick_cmd(n);
            if (op == CMD_REPLACE && shadow_fill > 0 && $urandom_range(0, 9) < 6)
                mid = shadow_ids[$urandom_range(0, shadow_fill - 1)];
            else
                mid = pick_id();
            send_request(op, pick_id(), 8'($urandom_range(0, 255)), mid);
        end
        s_tvalid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("lifo_stack_with_key_update regression: pass");
        else
            $display("lifo_stack_with_key_update regression: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lsk_pkg.sv
hdl/lsk_cell.sv
hdl/lsk_prio.sv
hdl/lifo_stack_with_key_update.sv
tb/sv/lifo_stack_with_key_update_tb.sv
